[design/retry_first_bounded_hash_queue_macros.svh]
// assertion macros shared by the queue's checker
`ifndef RETRY_FIRST_BOUNDED_HASH_QUEUE_MACROS_SVH
`define RETRY_FIRST_BOUNDED_HASH_QUEUE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define RBHQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rbhq: implication check failed");

// next-cycle implication, disabled while in reset
`define RBHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rbhq: next-cycle check failed");

`endif

[design/rbhq_pkg.sv]
// types and constants of the retry-first bounded hash queue
package rbhq_pkg;

  // widths fixed by the port payload
  localparam int HASH_W    = 64;
  localparam int FUNC_W    = 2;
  localparam int LIMIT_W   = 9;
  localparam int CNT_OUT_W = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  // function codes on the input beat
  localparam logic [FUNC_W-1:0] FUNC_PUSH_INC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_RET = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP      = 2'd2;

  // decoded operation
  typedef enum logic [1:0] {
    OP_PUSH_INC,
    OP_PUSH_RET,
    OP_POP,
    OP_NOP
  } op_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_EXEC,
    B_TRIM
  } bstate_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [HASH_W-1:0] hash_value;
  } in_t;

  typedef struct packed {
    logic [HASH_W-1:0]    popped_hash;
    logic                 popped_valid;
    logic                 empty_error;
    logic [CNT_OUT_W-1:0] dropped_count;
    logic [CNT_OUT_W-1:0] total_count;
  } res_t;

  typedef struct packed {
    op_e               op;
    logic [HASH_W-1:0] hash;
  } cmd_t;

  // handshake from front to back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

[design/rbhq_front.sv]
// front end: accepts beats, decodes the function code, holds a two-entry command queue
module rbhq_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  rbhq_pkg::in_t       item_i,
  input  logic                cmd_pop_i,
  output rbhq_pkg::cmd_chan_t cmd_o
);

  localparam logic [1:0] QDEPTH = 2'd2;

  rbhq_pkg::cmd_t q_mem [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           accept;
  logic           pop;
  rbhq_pkg::cmd_t dec;

  // decode the function code
  always_comb begin
    dec.hash = item_i.hash_value;
    case (item_i.func)
      rbhq_pkg::FUNC_PUSH_INC: dec.op = rbhq_pkg::OP_PUSH_INC;
      rbhq_pkg::FUNC_PUSH_RET: dec.op = rbhq_pkg::OP_PUSH_RET;
      rbhq_pkg::FUNC_POP:      dec.op = rbhq_pkg::OP_POP;
      default:                 dec.op = rbhq_pkg::OP_NOP;
    endcase
  end

  // queue control
  assign busy   = (cnt_q == QDEPTH);
  assign accept = start & ~busy;
  assign pop    = cmd_pop_i & (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = accept ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(accept) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

  assign cmd_o.valid = (cnt_q != 2'd0);
  assign cmd_o.cmd   = q_mem[rd_ptr_q];

endmodule

[design/rbhq_back.sv]
// back end: fifo stores, pointer and count update, trimming and result beat
module rbhq_back #(
  parameter int QUEUE_DEPTH = 256,
  parameter int HASH_BITS   = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rbhq_pkg::LIMIT_W-1:0]      cfg_wdata_i,
  input  rbhq_pkg::cmd_chan_t               cmd_i,
  output logic                              cmd_pop_o,
  output logic                              done_o,
  output rbhq_pkg::res_t                    res_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > rbhq_pkg::LIMIT_W) ? CW : rbhq_pkg::LIMIT_W;
  localparam int XW = LW + 1;
  localparam int OW = rbhq_pkg::CNT_OUT_W;
  localparam int HW = rbhq_pkg::HASH_W;

  // head plus offset, wrapped once around the ring
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] h, input logic [CW-1:0] n);
    logic [AW:0] s;
    s = (AW+1)'(h) + (AW+1)'(n);
    if (s >= (AW+1)'(QUEUE_DEPTH)) begin
      s = s - (AW+1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  rbhq_pkg::bstate_e state_q, state_d;
  rbhq_pkg::cmd_t    cmd_q;

  logic [rbhq_pkg::LIMIT_W-1:0] limit_q;
  logic [AW-1:0] hi_q, hi_d, hr_q, hr_d;
  logic [CW-1:0] ci_q, ci_d, cr_q, cr_d;

  // per-item scratch carried from execute to trim
  logic [XW-1:0] excess_q, excess_d;
  logic          drop1_q, drop1_d;
  logic          valid_q, valid_d;
  logic          err_q, err_d;
  logic          sel_q, sel_d;

  logic [HASH_BITS-1:0] inc_mem [QUEUE_DEPTH];
  logic [HASH_BITS-1:0] ret_mem [QUEUE_DEPTH];
  logic [HASH_BITS-1:0] inc_rd_q, ret_rd_q;

  logic          is_push, is_ret, is_pop, full;
  logic [AW-1:0] th, waddr;
  logic [CW-1:0] tc;
  logic [XW-1:0] lim, total, excess;
  logic          inc_we, ret_we, rd_en;
  logic [XW-1:0] cr_x, ci_x, d_r, rem, d_i, dropped;
  logic [CW:0]   tot_after;

  // sequencer: load a command, execute, then trim and report
  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      rbhq_pkg::B_IDLE: begin
        if (cmd_i.valid) begin
          cmd_pop_o = 1'b1;
          state_d   = rbhq_pkg::B_EXEC;
        end
      end
      rbhq_pkg::B_EXEC: begin
        state_d = rbhq_pkg::B_TRIM;
      end
      rbhq_pkg::B_TRIM: begin
        if (cmd_i.valid) begin
          cmd_pop_o = 1'b1;
          state_d   = rbhq_pkg::B_EXEC;
        end else begin
          state_d = rbhq_pkg::B_IDLE;
        end
      end
      default: state_d = rbhq_pkg::B_IDLE;
    endcase
  end

  // execute step decode
  assign is_push = (cmd_q.op == rbhq_pkg::OP_PUSH_INC) || (cmd_q.op == rbhq_pkg::OP_PUSH_RET);
  assign is_ret  = (cmd_q.op == rbhq_pkg::OP_PUSH_RET);
  assign is_pop  = (cmd_q.op == rbhq_pkg::OP_POP);
  assign tc      = is_ret ? cr_q : ci_q;
  assign th      = is_ret ? hr_q : hi_q;
  assign full    = (tc == CW'(QUEUE_DEPTH));
  assign waddr   = wrap_add(th, tc);

  // limit in effect and the excess after appending
  always_comb begin
    lim = (XW'(limit_q) > XW'(QUEUE_DEPTH)) ? XW'(QUEUE_DEPTH) : XW'(limit_q);
    total  = XW'(ci_q) + XW'(cr_q) + XW'(1);
    excess = (total > lim) ? (total - lim - XW'(full)) : '0;
  end

  // trim amounts, retry first and then incoming
  always_comb begin
    cr_x    = XW'(cr_q);
    ci_x    = XW'(ci_q);
    d_r     = (excess_q > cr_x) ? cr_x : excess_q;
    rem     = (excess_q > cr_x) ? (excess_q - cr_x) : '0;
    d_i     = (rem > ci_x) ? ci_x : rem;
    dropped = XW'(drop1_q) + d_r + d_i;
  end

  assign inc_we = (state_q == rbhq_pkg::B_EXEC) && is_push && !is_ret;
  assign ret_we = (state_q == rbhq_pkg::B_EXEC) && is_ret;
  assign rd_en  = (state_q == rbhq_pkg::B_EXEC) && is_pop;

  // next head and count values
  always_comb begin
    hi_d     = hi_q;
    ci_d     = ci_q;
    hr_d     = hr_q;
    cr_d     = cr_q;
    excess_d = excess_q;
    drop1_d  = drop1_q;
    valid_d  = valid_q;
    err_d    = err_q;
    sel_d    = sel_q;
    case (state_q)
      rbhq_pkg::B_EXEC: begin
        excess_d = '0;
        drop1_d  = 1'b0;
        valid_d  = 1'b0;
        err_d    = 1'b0;
        sel_d    = 1'b0;
        if (is_push) begin
          // a full target loses its head to make room
          excess_d = excess;
          drop1_d  = full;
          if (is_ret) begin
            hr_d = full ? wrap_add(hr_q, CW'(1)) : hr_q;
            cr_d = full ? cr_q : cr_q + CW'(1);
          end else begin
            hi_d = full ? wrap_add(hi_q, CW'(1)) : hi_q;
            ci_d = full ? ci_q : ci_q + CW'(1);
          end
        end else if (is_pop) begin
          if (cr_q != '0) begin
            hr_d    = wrap_add(hr_q, CW'(1));
            cr_d    = cr_q - CW'(1);
            valid_d = 1'b1;
            sel_d   = 1'b1;
          end else if (ci_q != '0) begin
            hi_d    = wrap_add(hi_q, CW'(1));
            ci_d    = ci_q - CW'(1);
            valid_d = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
      end
      rbhq_pkg::B_TRIM: begin
        hr_d = wrap_add(hr_q, CW'(d_r));
        cr_d = cr_q - CW'(d_r);
        hi_d = wrap_add(hi_q, CW'(d_i));
        ci_d = ci_q - CW'(d_i);
      end
      default: ;
    endcase
  end

  // control and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbhq_pkg::B_IDLE;
      limit_q <= rbhq_pkg::LIMIT_RESET;
      hi_q    <= '0;
      ci_q    <= '0;
      hr_q    <= '0;
      cr_q    <= '0;
    end else begin
      state_q <= state_d;
      hi_q    <= hi_d;
      ci_q    <= ci_d;
      hr_q    <= hr_d;
      cr_q    <= cr_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // command and scratch registers
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i.cmd;
    end
    excess_q <= excess_d;
    drop1_q  <= drop1_d;
    valid_q  <= valid_d;
    err_q    <= err_d;
    sel_q    <= sel_d;
  end

  // incoming fifo store
  always_ff @(posedge clk_i) begin
    if (inc_we) begin
      inc_mem[waddr] <= cmd_q.hash[HASH_BITS-1:0];
    end
    if (rd_en) begin
      inc_rd_q <= inc_mem[hi_q];
    end
  end

  // retry fifo store
  always_ff @(posedge clk_i) begin
    if (ret_we) begin
      ret_mem[waddr] <= cmd_q.hash[HASH_BITS-1:0];
    end
    if (rd_en) begin
      ret_rd_q <= ret_mem[hr_q];
    end
  end

  // result beat
  assign tot_after = (CW+1)'(ci_d) + (CW+1)'(cr_d);
  assign done_o    = (state_q == rbhq_pkg::B_TRIM);

  always_comb begin
    res_o.popped_hash   = valid_q ? HW'(sel_q ? ret_rd_q : inc_rd_q) : '0;
    res_o.popped_valid  = valid_q;
    res_o.empty_error   = err_q;
    res_o.dropped_count = OW'(dropped);
    res_o.total_count   = OW'(tot_after);
  end

endmodule

[design/retry_first_bounded_hash_queue.sv]
// Retry-first bounded hash queue, top level.
// With the back end idle, an accepted beat passes the command queue, then execute and trim.
// The back end works on one item at a time; the result strobe is high in its trim step.
// busy rises when the two-entry command queue is full; the receiver cannot stall.
// Reset clears heads, counts and queues and sets the limit to 256; stores are not cleared.
module retry_first_bounded_hash_queue #(
  parameter int QUEUE_DEPTH = 256,
  parameter int HASH_BITS   = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  rbhq_pkg::in_t                item_i,
  input  logic                         cfg_we_i,
  input  logic [rbhq_pkg::LIMIT_W-1:0] cfg_wdata_i,
  output logic                         done_o,
  output rbhq_pkg::res_t               res_o
);

  rbhq_pkg::cmd_chan_t cmd_chan;
  logic                cmd_pop;

  // decode and command queue
  rbhq_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .item_i    (item_i),
    .cmd_pop_i (cmd_pop),
    .cmd_o     (cmd_chan)
  );

  // fifo stores and sequencer
  rbhq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HASH_BITS   (HASH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_chan),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

[design/rbhq_checker.sv]
// port-level checks of the retry-first bounded hash queue and their bind
`include "retry_first_bounded_hash_queue_macros.svh"

module rbhq_checker #(
  parameter int QUEUE_DEPTH = 256
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           done_o,
  input rbhq_pkg::res_t res_o
);

  // result strobes never come back to back
  `RBHQ_ASSERT_NEXT(a_done_spaced, clk_i, rst_ni, done_o, !done_o)

  // an empty pop returns nothing
  `RBHQ_ASSERT_IMP(a_empty_no_data, clk_i, rst_ni, done_o && res_o.empty_error, !res_o.popped_valid && (res_o.popped_hash == '0))

  // a successful pop drops nothing
  `RBHQ_ASSERT_IMP(a_pop_no_drop, clk_i, rst_ni, done_o && res_o.popped_valid, (res_o.dropped_count == '0) && !res_o.empty_error)

  // occupancy never passes the depth
  `RBHQ_ASSERT_IMP(a_total_bound, clk_i, rst_ni, done_o, 32'(res_o.total_count) <= QUEUE_DEPTH)

endmodule

bind retry_first_bounded_hash_queue rbhq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_rbhq_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .done_o (done_o),
  .res_o  (res_o)
);

[bench/tb_retry_first_bounded_hash_queue.sv]
// testbench for the retry-first bounded hash queue: directed table plus random bursts
`timescale 1ns / 1ps

module tb_retry_first_bounded_hash_queue;

  localparam int QDEPTH = 256;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [rbhq_pkg::FUNC_W-1:0] FUNC_NOP = 2'd3;

  typedef enum logic {
    ROW_BEAT,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e                    kind;
    rbhq_pkg::in_t                beat;
    bit                           typed;
    rbhq_pkg::res_t               want;
    logic [rbhq_pkg::LIMIT_W-1:0] cfg_val;
  } dir_row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  rbhq_pkg::in_t                item_i = '0;
  logic                         cfg_we_i = 1'b0;
  logic [rbhq_pkg::LIMIT_W-1:0] cfg_wdata_i = '0;
  logic                         done_o;
  rbhq_pkg::res_t               res_o;

  // predictor state: both fifos and the limit register
  logic [rbhq_pkg::HASH_W-1:0]  inc_fifo[$];
  logic [rbhq_pkg::HASH_W-1:0]  rty_fifo[$];
  logic [rbhq_pkg::LIMIT_W-1:0] limit_q = rbhq_pkg::LIMIT_RESET;

  rbhq_pkg::res_t pending_results[$];
  dir_row_t       dir_rows[$];

  int err_count = 0;
  int n_beats = 0;
  int n_pop_hits = 0;
  int n_pop_empty = 0;
  int n_trimmed = 0;
  int n_full_push = 0;
  int n_limits = 0;
  int idle_cycles = 0;

  retry_first_bounded_hash_queue u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // expected result of one operation, updates the predictor's queues
  function automatic rbhq_pkg::res_t predict_queue_op(rbhq_pkg::in_t beat);
    rbhq_pkg::res_t r;
    int unsigned    lim;
    int unsigned    excess;
    int unsigned    drops;
    r = '0;
    drops = 0;
    case (beat.func)
      rbhq_pkg::FUNC_PUSH_INC, rbhq_pkg::FUNC_PUSH_RET: begin
        lim = (limit_q < QDEPTH) ? limit_q : QDEPTH;
        excess = inc_fifo.size() + rty_fifo.size() + 1;
        excess = (excess > lim) ? excess - lim : 0;
        // a full target fifo loses its own head first
        if (beat.func == rbhq_pkg::FUNC_PUSH_RET) begin
          if (rty_fifo.size() >= QDEPTH) begin
            rty_fifo.delete(0);
            excess--;
            drops++;
            n_full_push++;
          end
          rty_fifo.push_back(beat.hash_value);
        end else begin
          if (inc_fifo.size() >= QDEPTH) begin
            inc_fifo.delete(0);
            excess--;
            drops++;
            n_full_push++;
          end
          inc_fifo.push_back(beat.hash_value);
        end
        // trim oldest, retry side first
        while (excess > 0 && rty_fifo.size() > 0) begin
          rty_fifo.delete(0);
          excess--;
          drops++;
        end
        while (excess > 0 && inc_fifo.size() > 0) begin
          inc_fifo.delete(0);
          excess--;
          drops++;
        end
        r.dropped_count = drops[rbhq_pkg::CNT_OUT_W-1:0];
        n_trimmed += drops;
      end
      rbhq_pkg::FUNC_POP: begin
        if (rty_fifo.size() > 0) begin
          r.popped_hash = rty_fifo[0];
          rty_fifo.delete(0);
          r.popped_valid = 1'b1;
          n_pop_hits++;
        end else if (inc_fifo.size() > 0) begin
          r.popped_hash = inc_fifo[0];
          inc_fifo.delete(0);
          r.popped_valid = 1'b1;
          n_pop_hits++;
        end else begin
          r.empty_error = 1'b1;
          n_pop_empty++;
        end
      end
      default: begin
      end
    endcase
    r.total_count = rbhq_pkg::CNT_OUT_W'(inc_fifo.size() + rty_fifo.size());
    return r;
  endfunction

  function automatic dir_row_t beat_row(logic [rbhq_pkg::FUNC_W-1:0] f,
                                        logic [rbhq_pkg::HASH_W-1:0] h);
    dir_row_t row;
    row.kind = ROW_BEAT;
    row.beat.func = f;
    row.beat.hash_value = h;
    row.typed = 1'b0;
    row.want = '0;
    row.cfg_val = '0;
    return row;
  endfunction

  function automatic dir_row_t typed_row(logic [rbhq_pkg::FUNC_W-1:0] f,
                                         logic [rbhq_pkg::HASH_W-1:0] h,
                                         logic [rbhq_pkg::HASH_W-1:0] ph, logic pv, logic ee,
                                         logic [rbhq_pkg::CNT_OUT_W-1:0] dc,
                                         logic [rbhq_pkg::CNT_OUT_W-1:0] tc);
    dir_row_t row;
    row = beat_row(f, h);
    row.typed = 1'b1;
    row.want.popped_hash = ph;
    row.want.popped_valid = pv;
    row.want.empty_error = ee;
    row.want.dropped_count = dc;
    row.want.total_count = tc;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [rbhq_pkg::LIMIT_W-1:0] v);
    dir_row_t row;
    row = beat_row(FUNC_NOP, '0);
    row.kind = ROW_CFG;
    row.cfg_val = v;
    return row;
  endfunction

  // drive one beat and hold it until the block takes it
  task automatic send_beat(rbhq_pkg::in_t beat, bit typed, rbhq_pkg::res_t want);
    rbhq_pkg::res_t pred;
    item_i <= beat;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pred = predict_queue_op(beat);
    pending_results.push_back(typed ? want : pred);
    n_beats++;
  endtask

  // limit register only changes with the block drained
  task automatic write_limit(logic [rbhq_pkg::LIMIT_W-1:0] v);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    limit_q = v;
    cfg_we_i <= 1'b0;
    n_limits++;
  endtask

  // random traffic in bursts with gaps, biased toward push or pop
  task automatic run_random(logic [rbhq_pkg::LIMIT_W-1:0] lim, int n, int push_pct,
                            int retry_pct);
    int             burst_left;
    int             gap;
    int             pick;
    rbhq_pkg::in_t  beat;
    rbhq_pkg::res_t none;
    burst_left = 0;
    none = '0;
    write_limit(lim);
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      pick = $urandom_range(0, 99);
      beat.hash_value = {$urandom, $urandom};
      if (pick < 3)
        beat.func = FUNC_NOP;
      else if (pick < push_pct)
        beat.func = ($urandom_range(0, 99) < retry_pct) ? rbhq_pkg::FUNC_PUSH_RET
                                                         : rbhq_pkg::FUNC_PUSH_INC;
      else
        beat.func = rbhq_pkg::FUNC_POP;
      send_beat(beat, 1'b0, none);
      burst_left--;
    end
  endtask

  // result check against the oldest expectation
  always @(posedge clk_i) begin
    rbhq_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting: hash %0h total %0d",
               res_o.popped_hash, res_o.total_count);
        err_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (res_o.popped_hash !== want.popped_hash) begin
          $error("popped_hash exp %0h got %0h", want.popped_hash, res_o.popped_hash);
          err_count++;
        end
        if (res_o.popped_valid !== want.popped_valid) begin
          $error("popped_valid exp %0h got %0h", want.popped_valid, res_o.popped_valid);
          err_count++;
        end
        if (res_o.empty_error !== want.empty_error) begin
          $error("empty_error exp %0h got %0h", want.empty_error, res_o.empty_error);
          err_count++;
        end
        if (res_o.dropped_count !== want.dropped_count) begin
          $error("dropped_count exp %0d got %0d", want.dropped_count, res_o.dropped_count);
          err_count++;
        end
        if (res_o.total_count !== want.total_count) begin
          $error("total_count exp %0d got %0d", want.total_count, res_o.total_count);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat taken and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, pending_results.size());
      $display("retry_first_bounded_hash_queue verification failed");
      $finish;
    end
  end

  initial begin
    dir_row_t row;

    // directed table, limit at its reset value first
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_POP, 64'h0, 64'h0, 1'b0, 1'b1, 9'd0, 9'd0));
    dir_rows.push_back(typed_row(FUNC_NOP, '1, 64'h0, 1'b0, 1'b0, 9'd0, 9'd0));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_PUSH_INC, '1, 64'h0, 1'b0, 1'b0, 9'd0, 9'd1));
    dir_rows.push_back(beat_row(rbhq_pkg::FUNC_PUSH_RET, 64'h0));
    dir_rows.push_back(beat_row(rbhq_pkg::FUNC_PUSH_INC, 64'h1));
    // retry head leaves first, then incoming in order
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_POP, 64'h0, 64'h0, 1'b1, 1'b0, 9'd0, 9'd2));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_POP, 64'h0, '1, 1'b1, 1'b0, 9'd0, 9'd1));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_POP, '1, 64'h1, 1'b1, 1'b0, 9'd0, 9'd0));
    dir_rows.push_back(beat_row(rbhq_pkg::FUNC_PUSH_RET, 64'h8000_0000_0000_0000));
    dir_rows.push_back(beat_row(rbhq_pkg::FUNC_PUSH_INC, 64'h5555_5555_5555_5555));
    dir_rows.push_back(beat_row(rbhq_pkg::FUNC_PUSH_RET, 64'hAAAA_AAAA_AAAA_AAAA));
    // limit lowered below the held count: no trim until the next push
    dir_rows.push_back(cfg_row(9'd1));
    dir_rows.push_back(typed_row(FUNC_NOP, 64'h0, 64'h0, 1'b0, 1'b0, 9'd0, 9'd3));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_PUSH_INC, 64'h0123_4567_89AB_CDEF,
                                 64'h0, 1'b0, 1'b0, 9'd3, 9'd1));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_POP, 64'h0, 64'h0123_4567_89AB_CDEF,
                                 1'b1, 1'b0, 9'd0, 9'd0));
    // zero limit drops the new hash too
    dir_rows.push_back(cfg_row(9'd0));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_PUSH_INC, '1, 64'h0, 1'b0, 1'b0, 9'd1, 9'd0));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_PUSH_RET, 64'h1, 64'h0, 1'b0, 1'b0, 9'd1, 9'd0));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_POP, 64'h0, 64'h0, 1'b0, 1'b1, 9'd0, 9'd0));
    // limit above depth
    dir_rows.push_back(cfg_row(9'd511));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_PUSH_RET, 64'h2, 64'h0, 1'b0, 1'b0, 9'd0, 9'd1));
    dir_rows.push_back(typed_row(rbhq_pkg::FUNC_POP, 64'h0, 64'h2, 1'b1, 1'b0, 9'd0, 9'd0));

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG)
        write_limit(row.cfg_val);
      else
        send_beat(row.beat, row.typed, row.want);
    end

    // mixed, incoming overfill, drain, tight trim, retry-heavy, zero and random limit
    run_random(9'd256, 150, 55, 40);
    run_random(9'd511, 300, 95, 0);
    run_random(9'd300, 80, 30, 50);
    run_random(9'd4, 120, 60, 50);
    run_random(9'd257, 300, 90, 100);
    run_random(9'd0, 40, 60, 50);
    run_random(rbhq_pkg::LIMIT_W'($urandom_range(0, 511)), 60, 55, 50);
    start <= 1'b0;

    // drain and let trailing results settle
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d beats over %0d limit settings: %0d pops hit, %0d pops on empty",
             n_beats, n_limits, n_pop_hits, n_pop_empty);
    $display("  %0d entries trimmed, %0d pushes into a full fifo", n_trimmed, n_full_push);
    if (err_count == 0)
      $display("retry_first_bounded_hash_queue verification clean");
    else
      $display("retry_first_bounded_hash_queue verification failed");
    $finish;
  end

endmodule
